/* src/cbor_item_head_tokenizer_top_defines.svh */
`ifndef CBOR_ITEM_HEAD_TOKENIZER_TOP_DEFINES_SVH
`define CBOR_ITEM_HEAD_TOKENIZER_TOP_DEFINES_SVH

// concurrent checks, compiled out for synthesis
`ifndef SYNTHESIS
`define CBOR_IHT_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("cbor tokenizer check failed");
`define CBOR_IHT_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("cbor tokenizer check failed");
`else
`define CBOR_IHT_ASSERT(name, clk, rstn, prop)
`define CBOR_IHT_ASSERT_NEXT(name, clk, rstn, ante, cons)
`endif

`endif

/* src/cbor_iht_pkg.sv */
`timescale 1ns / 1ps

package cbor_iht_pkg;

  localparam int unsigned CfgW    = 17;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned ArgW    = 64;
  localparam int unsigned PayW    = 17;

  // parse phases
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_ARG  = 2'd1;
  localparam logic [1:0] PH_PAY  = 2'd2;
  localparam logic [1:0] PH_ERR  = 2'd3;

  // major types with length limits
  localparam logic [2:0] MT_BYTES = 3'd2;
  localparam logic [2:0] MT_TEXT  = 3'd3;
  localparam logic [2:0] MT_ARRAY = 3'd4;
  localparam logic [2:0] MT_MAP   = 3'd5;

  localparam logic [9:0]  ITEM_LIMIT_RST  = 10'd512;
  localparam logic [15:0] TEXT_LIMIT_RST  = 16'd1024;
  localparam logic [16:0] BYTES_LIMIT_RST = 17'd65536;
  localparam logic [9:0]  CONT_LIMIT_RST  = 10'd512;

  localparam logic [20:0] CP_MAX       = 21'h10ffff;
  localparam logic [20:0] CP_SURR_LO   = 21'h00d800;
  localparam logic [20:0] CP_SURR_HI   = 21'h00dfff;
  localparam logic [20:0] CP_MIN_SEQ2  = 21'h000080;
  localparam logic [20:0] CP_MIN_SEQ3  = 21'h000800;
  localparam logic [20:0] CP_MIN_SEQ4  = 21'h010000;

  typedef enum logic [1:0] {
    EV_PENDING = 2'd0,
    EV_HEAD    = 2'd1,
    EV_PAYLOAD = 2'd2,
    EV_ERROR   = 2'd3
  } event_e;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_ITEMS    = 3'd1,
    ERR_RESERVED = 3'd2,
    ERR_NONMIN   = 3'd3,
    ERR_LENGTH   = 3'd4,
    ERR_UTF8     = 3'd5,
    ERR_TRUNC    = 3'd6
  } err_e;

  typedef enum logic [1:0] {
    REG_ITEM_LIMIT  = 2'd0,
    REG_TEXT_LIMIT  = 2'd1,
    REG_BYTES_LIMIT = 2'd2,
    REG_CONT_LIMIT  = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [9:0]  item_limit;
    logic [15:0] text_limit;
    logic [16:0] bytes_limit;
    logic [9:0]  container_limit;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  cont_left;
    logic [1:0]  seq_len;
    logic [20:0] cp;
  } utf8_state_t;

  typedef struct packed {
    event_e          event_res;
    logic [2:0]      major_type;
    logic [ArgW-1:0] argument;
    logic [7:0]      payload_byte;
    err_e            error_code;
    logic            buffer_ok;
  } result_t;

  typedef struct packed {
    logic [1:0] phase;
    err_e       sticky_err;
    logic [9:0] item_count;
  } core_status_t;

  // smallest argument that needs the given extension width
  function automatic logic [ArgW-1:0] min_by_width(logic [1:0] width_code);
    logic [ArgW-1:0] m;
    case (width_code)
      2'd0:    m = 64'd24;
      2'd1:    m = 64'h100;
      2'd2:    m = 64'h10000;
      default: m = 64'h1_0000_0000;
    endcase
    return m;
  endfunction

endpackage

/* src/cbor_iht_in_if.sv */
`timescale 1ns / 1ps

interface cbor_iht_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       buffer_end;

  modport source (output valid, output in_byte, output buffer_end, input ready);
  modport sink (input valid, input in_byte, input buffer_end, output ready);
endinterface

/* src/cbor_iht_out_if.sv */
`timescale 1ns / 1ps

interface cbor_iht_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_res;
  logic [2:0]  major_type;
  logic [63:0] argument;
  logic [7:0]  payload_byte;
  logic [2:0]  error_code;
  logic        buffer_ok;

  modport source (
    output valid, output event_res, output major_type, output argument,
    output payload_byte, output error_code, output buffer_ok, input ready
  );
  modport sink (
    input valid, input event_res, input major_type, input argument,
    input payload_byte, input error_code, input buffer_ok, output ready
  );
endinterface

/* src/cbor_item_head_tokenizer_top.sv */
`timescale 1ns / 1ps

// CBOR head tokenizer: takes one buffer byte per transfer and returns exactly one result per
// byte in the cycle after it is taken and sustains one byte per clock while the output
// takes each result. The throughput is set by the combinational parse state update (head
// argument shift, string byte count and UTF-8 decoder); while a result waits in the result
// register the input is held off; a new byte enters in the same cycle the waiting result
// is taken. The user must write limits through the cfg port only while idle; the block
// does not enforce it. Errors stick until the buffer end, which also clears all parse state.
`include "cbor_item_head_tokenizer_top_defines.svh"

module cbor_item_head_tokenizer_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  cbor_iht_in_if.sink                       in_i,
  cbor_iht_out_if.source                    out_o,
  input  logic                              cfg_we_i,
  input  logic [cbor_iht_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [cbor_iht_pkg::CfgW-1:0]     cfg_wdata_i
);

  cbor_iht_pkg::cfg_t            cfg;
  cbor_iht_pkg::result_t         res;
  cbor_iht_pkg::result_t         res_q;
  cbor_iht_pkg::core_status_t    status;
  logic                          out_valid_q;
  logic                          step;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign step       = in_i.valid && in_i.ready;

  cbor_iht_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  cbor_iht_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .in_byte_i    (in_i.in_byte),
    .buffer_end_i (in_i.buffer_end),
    .cfg_i        (cfg),
    .res_o        (res),
    .status_o     (status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      out_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.event_res    = res_q.event_res;
  assign out_o.major_type   = res_q.major_type;
  assign out_o.argument     = res_q.argument;
  assign out_o.payload_byte = res_q.payload_byte;
  assign out_o.error_code   = res_q.error_code;
  assign out_o.buffer_ok    = res_q.buffer_ok;

  // an error event always carries its code, and only an error event does
  `CBOR_IHT_ASSERT(a_err_code_match, clk_i, rst_ni, !out_valid_q || ((res_q.event_res == cbor_iht_pkg::EV_ERROR) == (res_q.error_code != cbor_iht_pkg::ERR_NONE)))
  `CBOR_IHT_ASSERT(a_ok_no_err, clk_i, rst_ni, !(out_valid_q && res_q.buffer_ok) || res_q.event_res != cbor_iht_pkg::EV_ERROR)
  `CBOR_IHT_ASSERT(a_arg_only_head, clk_i, rst_ni, !out_valid_q || res_q.event_res == cbor_iht_pkg::EV_HEAD || res_q.argument == '0)
  `CBOR_IHT_ASSERT_NEXT(a_end_clears, clk_i, rst_ni, step && in_i.buffer_end, status.phase == cbor_iht_pkg::PH_IDLE && status.sticky_err == cbor_iht_pkg::ERR_NONE && status.item_count == '0)

endmodule

/* src/cbor_iht_cfg.sv */
`timescale 1ns / 1ps

module cbor_iht_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [cbor_iht_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [cbor_iht_pkg::CfgW-1:0]      cfg_wdata_i,
  output cbor_iht_pkg::cfg_t                 cfg_o
);

  cbor_iht_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cbor_iht_pkg::reg_idx_e'(cfg_idx_i))
        cbor_iht_pkg::REG_ITEM_LIMIT:  cfg_d.item_limit      = cfg_wdata_i[9:0];
        cbor_iht_pkg::REG_TEXT_LIMIT:  cfg_d.text_limit      = cfg_wdata_i[15:0];
        cbor_iht_pkg::REG_BYTES_LIMIT: cfg_d.bytes_limit     = cfg_wdata_i[16:0];
        cbor_iht_pkg::REG_CONT_LIMIT:  cfg_d.container_limit = cfg_wdata_i[9:0];
        default:                       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.item_limit      <= cbor_iht_pkg::ITEM_LIMIT_RST;
      cfg_q.text_limit      <= cbor_iht_pkg::TEXT_LIMIT_RST;
      cfg_q.bytes_limit     <= cbor_iht_pkg::BYTES_LIMIT_RST;
      cfg_q.container_limit <= cbor_iht_pkg::CONT_LIMIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* src/cbor_iht_utf8.sv */
`timescale 1ns / 1ps

module cbor_iht_utf8 (
  input  logic [7:0]                 byte_i,
  input  cbor_iht_pkg::utf8_state_t  state_i,
  output logic                       ok_o,
  output cbor_iht_pkg::utf8_state_t  state_o
);

  logic [20:0] cp_next;
  logic [1:0]  cont_m1;
  logic        overlong;

  assign cp_next = {state_i.cp[14:0], byte_i[5:0]};
  assign cont_m1 = state_i.cont_left - 2'd1;

  always_comb begin
    state_o  = state_i;
    ok_o     = 1'b1;
    overlong = 1'b0;
    if (state_i.cont_left == 2'd0) begin
      // lead byte
      if (!byte_i[7]) begin
        ok_o = 1'b1;
      end else if (byte_i[7:5] == 3'b110) begin
        state_o.seq_len   = 2'd1;
        state_o.cont_left = 2'd1;
        state_o.cp        = {16'd0, byte_i[4:0]};
      end else if (byte_i[7:4] == 4'b1110) begin
        state_o.seq_len   = 2'd2;
        state_o.cont_left = 2'd2;
        state_o.cp        = {17'd0, byte_i[3:0]};
      end else if (byte_i[7:3] == 5'b11110) begin
        state_o.seq_len   = 2'd3;
        state_o.cont_left = 2'd3;
        state_o.cp        = {18'd0, byte_i[2:0]};
      end else begin
        ok_o = 1'b0;
      end
    end else if (byte_i[7:6] != 2'b10) begin
      ok_o = 1'b0;
    end else begin
      state_o.cp        = cp_next;
      state_o.cont_left = cont_m1;
      if (cont_m1 == 2'd0) begin
        case (state_i.seq_len)
          2'd1:    overlong = cp_next < cbor_iht_pkg::CP_MIN_SEQ2;
          2'd2:    overlong = cp_next < cbor_iht_pkg::CP_MIN_SEQ3;
          2'd3:    overlong = cp_next < cbor_iht_pkg::CP_MIN_SEQ4;
          default: overlong = 1'b0;
        endcase
        ok_o = !(overlong || cp_next > cbor_iht_pkg::CP_MAX ||
                 (cp_next >= cbor_iht_pkg::CP_SURR_LO &&
                  cp_next <= cbor_iht_pkg::CP_SURR_HI));
      end
    end
  end

endmodule

/* src/cbor_iht_core.sv */
`timescale 1ns / 1ps

module cbor_iht_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic [7:0]                  in_byte_i,
  input  logic                        buffer_end_i,
  input  cbor_iht_pkg::cfg_t          cfg_i,
  output cbor_iht_pkg::result_t       res_o,
  output cbor_iht_pkg::core_status_t  status_o
);

  logic [1:0]                      phase_q, phase_d;
  logic [2:0]                      major_q, major_d;
  logic [3:0]                      arg_left_q, arg_left_d;
  logic [1:0]                      width_q, width_d;
  logic [cbor_iht_pkg::ArgW-1:0]   acc_q, acc_d;
  logic [9:0]                      item_cnt_q, item_cnt_d;
  logic [cbor_iht_pkg::PayW-1:0]   pay_left_q, pay_left_d;
  cbor_iht_pkg::utf8_state_t       utf_q, utf_d, utf_next;
  cbor_iht_pkg::err_e              err_q, err_d;

  logic                            utf_ok;
  logic [cbor_iht_pkg::ArgW-1:0]   acc_next;
  logic [3:0]                      left_next;
  logic [4:0]                      ai;
  logic                            head_done;
  logic [cbor_iht_pkg::ArgW-1:0]   head_v;
  logic                            over_lim;
  cbor_iht_pkg::event_e            ev;
  logic [cbor_iht_pkg::ArgW-1:0]   arg;
  logic [7:0]                      pb;
  logic                            ok;

  cbor_iht_utf8 u_utf8 (
    .byte_i  (in_byte_i),
    .state_i (utf_q),
    .ok_o    (utf_ok),
    .state_o (utf_next)
  );

  assign acc_next  = {acc_q[cbor_iht_pkg::ArgW-9:0], in_byte_i};
  assign left_next = arg_left_q - 4'd1;
  assign ai        = in_byte_i[4:0];

  always_comb begin
    phase_d    = phase_q;
    major_d    = major_q;
    arg_left_d = arg_left_q;
    width_d    = width_q;
    acc_d      = acc_q;
    item_cnt_d = item_cnt_q;
    pay_left_d = pay_left_q;
    utf_d      = utf_q;
    err_d      = err_q;
    ev         = cbor_iht_pkg::EV_PENDING;
    arg        = '0;
    pb         = in_byte_i;
    ok         = 1'b0;
    head_done  = 1'b0;
    head_v     = '0;
    over_lim   = 1'b0;

    unique case (phase_q)
      cbor_iht_pkg::PH_ERR: begin
        ev = cbor_iht_pkg::EV_ERROR;
      end
      cbor_iht_pkg::PH_IDLE: begin
        major_d = in_byte_i[7:5];
        if (item_cnt_q >= cfg_i.item_limit) begin
          ev      = cbor_iht_pkg::EV_ERROR;
          err_d   = cbor_iht_pkg::ERR_ITEMS;
          phase_d = cbor_iht_pkg::PH_ERR;
        end else begin
          item_cnt_d = item_cnt_q + 10'd1;
          if (ai < 5'd24) begin
            head_done = 1'b1;
            head_v    = {59'd0, ai};
          end else if (ai <= 5'd27) begin
            // 24..27 select 1, 2, 4 or 8 argument bytes
            width_d    = ai[1:0];
            arg_left_d = 4'd1 << ai[1:0];
            acc_d      = '0;
            phase_d    = cbor_iht_pkg::PH_ARG;
          end else begin
            ev      = cbor_iht_pkg::EV_ERROR;
            err_d   = cbor_iht_pkg::ERR_RESERVED;
            phase_d = cbor_iht_pkg::PH_ERR;
          end
        end
      end
      cbor_iht_pkg::PH_ARG: begin
        acc_d      = acc_next;
        arg_left_d = left_next;
        if (left_next == 4'd0) begin
          if (acc_next < cbor_iht_pkg::min_by_width(width_q)) begin
            ev      = cbor_iht_pkg::EV_ERROR;
            err_d   = cbor_iht_pkg::ERR_NONMIN;
            phase_d = cbor_iht_pkg::PH_ERR;
          end else begin
            head_done = 1'b1;
            head_v    = acc_next;
          end
        end
      end
      cbor_iht_pkg::PH_PAY: begin
        ev = cbor_iht_pkg::EV_PAYLOAD;
        if (major_q == cbor_iht_pkg::MT_TEXT && !utf_ok) begin
          ev      = cbor_iht_pkg::EV_ERROR;
          err_d   = cbor_iht_pkg::ERR_UTF8;
          phase_d = cbor_iht_pkg::PH_ERR;
        end else begin
          if (major_q == cbor_iht_pkg::MT_TEXT) begin
            utf_d = utf_next;
          end
          pay_left_d = pay_left_q - 17'd1;
          if (pay_left_d == '0) begin
            // string ended inside a multi-byte sequence
            if (major_q == cbor_iht_pkg::MT_TEXT && utf_next.cont_left != 2'd0) begin
              ev      = cbor_iht_pkg::EV_ERROR;
              err_d   = cbor_iht_pkg::ERR_UTF8;
              phase_d = cbor_iht_pkg::PH_ERR;
            end else begin
              phase_d = cbor_iht_pkg::PH_IDLE;
            end
          end
        end
      end
      default: ev = cbor_iht_pkg::EV_ERROR;
    endcase

    if (head_done) begin
      case (major_d)
        cbor_iht_pkg::MT_BYTES: over_lim = head_v > {47'd0, cfg_i.bytes_limit};
        cbor_iht_pkg::MT_TEXT:  over_lim = head_v > {48'd0, cfg_i.text_limit};
        cbor_iht_pkg::MT_ARRAY,
        cbor_iht_pkg::MT_MAP:   over_lim = head_v > {54'd0, cfg_i.container_limit};
        default:                over_lim = 1'b0;
      endcase
      if (over_lim) begin
        ev      = cbor_iht_pkg::EV_ERROR;
        err_d   = cbor_iht_pkg::ERR_LENGTH;
        phase_d = cbor_iht_pkg::PH_ERR;
      end else begin
        ev  = cbor_iht_pkg::EV_HEAD;
        arg = head_v;
        if ((major_d == cbor_iht_pkg::MT_BYTES || major_d == cbor_iht_pkg::MT_TEXT) &&
            head_v != '0) begin
          phase_d    = cbor_iht_pkg::PH_PAY;
          pay_left_d = head_v[cbor_iht_pkg::PayW-1:0];
          utf_d      = '0;
        end else begin
          phase_d = cbor_iht_pkg::PH_IDLE;
        end
      end
    end

    if (buffer_end_i) begin
      if (err_d == cbor_iht_pkg::ERR_NONE && phase_d != cbor_iht_pkg::PH_IDLE) begin
        ev      = cbor_iht_pkg::EV_ERROR;
        err_d   = cbor_iht_pkg::ERR_TRUNC;
        phase_d = cbor_iht_pkg::PH_ERR;
      end
      ok = (err_d == cbor_iht_pkg::ERR_NONE);
    end
  end

  always_comb begin
    res_o.event_res    = ev;
    res_o.major_type   = major_d;
    res_o.argument     = (ev == cbor_iht_pkg::EV_HEAD) ? arg : '0;
    res_o.payload_byte = (ev == cbor_iht_pkg::EV_PAYLOAD) ? pb : 8'd0;
    res_o.error_code   = (ev == cbor_iht_pkg::EV_ERROR) ? err_d : cbor_iht_pkg::ERR_NONE;
    res_o.buffer_ok    = ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= cbor_iht_pkg::PH_IDLE;
      major_q    <= '0;
      arg_left_q <= '0;
      width_q    <= '0;
      acc_q      <= '0;
      item_cnt_q <= '0;
      pay_left_q <= '0;
      utf_q      <= '0;
      err_q      <= cbor_iht_pkg::ERR_NONE;
    end else if (step_i) begin
      if (buffer_end_i) begin
        // last byte of the buffer: restart parsing
        phase_q    <= cbor_iht_pkg::PH_IDLE;
        major_q    <= '0;
        arg_left_q <= '0;
        width_q    <= '0;
        acc_q      <= '0;
        item_cnt_q <= '0;
        pay_left_q <= '0;
        utf_q      <= '0;
        err_q      <= cbor_iht_pkg::ERR_NONE;
      end else begin
        phase_q    <= phase_d;
        major_q    <= major_d;
        arg_left_q <= arg_left_d;
        width_q    <= width_d;
        acc_q      <= acc_d;
        item_cnt_q <= item_cnt_d;
        pay_left_q <= pay_left_d;
        utf_q      <= utf_d;
        err_q      <= err_d;
      end
    end
  end

  assign status_o.phase      = phase_q;
  assign status_o.sticky_err = err_q;
  assign status_o.item_count = item_cnt_q;

endmodule
